/* sv/rcs_pkg.sv */
// package: shared types and constants for the wall column texel shader
`timescale 1ns / 1ps
package rcs_pkg;
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [1:0] REG_SCREEN_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd2;

  localparam int STRIP_W   = 16;
  localparam logic [STRIP_W-1:0] STRIP_MAX = 16'hFFFF;

  typedef struct packed {
    logic       ok;
    logic [9:0] col;
    logic [9:0] row;
    logic       ns;
  } rcs_tag_t;
endpackage

/* sv/raycast_wall_column_texel_shader.sv */
// top level: textured wall strip pixel shader with texture memory
// stages from input transfer to output: strip divider, A, B, row divider, D, output register
// throughput: one item per cycle unless stalled; texel writes and renders share one stream
// the whole pipe advances together and stalls when the output is held; a texel
// write also waits until every earlier render has made its memory read
// reset: registers return to 480 / 64 / 64, pipe empties; texture memory
// keeps no reset; the user must read a texel only after it is written, the block itself does not enforce this
`timescale 1ns / 1ps
module raycast_wall_column_texel_shader #(
  parameter int TEXTURE_COUNT      = 8,
  parameter int MAX_TEXTURE_WIDTH  = 64,
  parameter int MAX_TEXTURE_HEIGHT = 64,
  parameter int MAX_SCREEN_SIZE    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_texture_key,
  input  logic [5:0]  in_texel_column,
  input  logic [5:0]  in_texel_row,
  input  logic [23:0] in_texel_color,
  input  logic [23:0] in_wall_distance,
  input  logic [15:0] in_hit_fraction,
  input  logic        in_wall_is_north_south,
  input  logic        in_ray_dir_x_positive,
  input  logic        in_ray_dir_y_negative,
  input  logic [9:0]  in_screen_column,
  input  logic [9:0]  in_screen_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_out_column,
  output logic [9:0]  out_out_row,
  output logic [7:0]  out_pixel_red,
  output logic [7:0]  out_pixel_green,
  output logic [7:0]  out_pixel_blue,
  output logic [7:0]  out_pixel_alpha,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int KEY_W   = (TEXTURE_COUNT > 1) ? $clog2(TEXTURE_COUNT) : 1;
  localparam int TXW_W   = $clog2(MAX_TEXTURE_WIDTH);
  localparam int TXH_W   = $clog2(MAX_TEXTURE_HEIGHT);
  localparam int ADDR_W  = KEY_W + TXH_W + TXW_W;
  localparam int DEPTH   = TEXTURE_COUNT * MAX_TEXTURE_HEIGHT * MAX_TEXTURE_WIDTH;
  localparam int SH_W    = $clog2(MAX_SCREEN_SIZE) + 1;
  localparam int TW_W    = TXW_W + 1;
  localparam int TH_W    = TXH_W + 1;
  localparam int NUM1_W  = SH_W + 16;
  localparam int NUM2_W  = 17 + TH_W;
  localparam int TOP_W   = 18;

  // ---------------- configuration registers ----------------
  logic [10:0] sh_raw;
  logic [6:0]  tw_raw, th_raw;
  logic [SH_W-1:0] screen_height_r;
  logic [TW_W-1:0] texture_width_r;
  logic [TH_W-1:0] texture_height_r;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign sh_raw     = cfg_pwdata[10:0];
  assign tw_raw     = cfg_pwdata[6:0];
  assign th_raw     = cfg_pwdata[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r  <= SH_W'(480);
      texture_width_r  <= TW_W'(64);
      texture_height_r <= TH_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        rcs_pkg::REG_SCREEN_HEIGHT: begin
          if (sh_raw == '0) screen_height_r <= SH_W'(1);
          else if (32'(sh_raw) > MAX_SCREEN_SIZE) screen_height_r <= SH_W'(MAX_SCREEN_SIZE);
          else screen_height_r <= SH_W'(sh_raw);
        end
        rcs_pkg::REG_TEXTURE_WIDTH: begin
          if (tw_raw == '0) texture_width_r <= TW_W'(1);
          else if (32'(tw_raw) > MAX_TEXTURE_WIDTH)
            texture_width_r <= TW_W'(MAX_TEXTURE_WIDTH);
          else texture_width_r <= TW_W'(tw_raw);
        end
        rcs_pkg::REG_TEXTURE_HEIGHT: begin
          if (th_raw == '0) texture_height_r <= TH_W'(1);
          else if (32'(th_raw) > MAX_TEXTURE_HEIGHT)
            texture_height_r <= TH_W'(MAX_TEXTURE_HEIGHT);
          else texture_height_r <= TH_W'(th_raw);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      rcs_pkg::REG_SCREEN_HEIGHT:  cfg_prdata = 32'(screen_height_r);
      rcs_pkg::REG_TEXTURE_WIDTH:  cfg_prdata = 32'(texture_width_r);
      rcs_pkg::REG_TEXTURE_HEIGHT: cfg_prdata = 32'(texture_height_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- pipe control ----------------
  // the pipe moves as a whole; a held output freezes every stage
  logic stall;
  logic in_xfer;
  logic wr_block;
  assign stall    = out_valid && !out_ready;
  assign in_ready = !stall && !wr_block;
  assign in_xfer  = in_valid && in_ready;

  // texel writes go straight to memory once no render is still ahead of its read
  logic key_ok;
  assign key_ok = (in_texture_key != '0) && (32'(in_texture_key) <= TEXTURE_COUNT);

  logic [23:0] tex_mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  key_m1;
  assign key_m1  = KEY_W'(in_texture_key - 4'd1);
  assign wr_addr = {key_m1, TXH_W'(in_texel_row), TXW_W'(in_texel_column)};

  logic wr_row_ok, wr_col_ok;
  assign wr_row_ok = 32'(in_texel_row) < MAX_TEXTURE_HEIGHT;
  assign wr_col_ok = 32'(in_texel_column) < MAX_TEXTURE_WIDTH;

  // stage 0: strip height division, side data carried along
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [15:0]      frac;
    logic             ns;
    logic             mir;
    logic [9:0]       col;
    logic [9:0]       row;
  } s1_side_t;

  s1_side_t s1_in, s1_out;
  logic [23:0] dist_nz;
  logic [NUM1_W-1:0] strip_quot;
  logic s1_valid;
  assign dist_nz = (in_wall_distance == '0) ? 24'd1 : in_wall_distance;
  assign s1_in = '{ok: key_ok, key: key_m1, frac: in_hit_fraction,
                   ns: in_wall_is_north_south,
                   mir: (in_wall_is_north_south && in_ray_dir_x_positive) ||
                        (!in_wall_is_north_south && in_ray_dir_y_negative),
                   col: in_screen_column, row: in_screen_row};

  rcs_divider #(.NUM_W(NUM1_W), .DEN_W(24), .SIDE_W($bits(s1_side_t))) u_strip_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_xfer && in_opcode == rcs_pkg::OP_RENDER),
    .stall(stall),
    .in_num({screen_height_r, 16'd0}),
    .in_den(dist_nz),
    .in_side(s1_in),
    .out_valid(s1_valid), .out_quot(strip_quot), .out_side(s1_out)
  );

  // stage A: saturate strip, compute top, bounds and texture column
  logic [rcs_pkg::STRIP_W-1:0] strip;
  logic signed [TOP_W-1:0] top, endv, ypos, beginv;
  logic in_strip;
  logic [TW_W+16-1:0] tx_prod;
  logic [TXW_W-1:0] tx;
  assign strip = (strip_quot > NUM1_W'(rcs_pkg::STRIP_MAX)) ? rcs_pkg::STRIP_MAX
                 : rcs_pkg::STRIP_W'(strip_quot);
  assign top    = TOP_W'(screen_height_r >> 1) - TOP_W'(strip >> 1);
  assign beginv = (top > 0) ? top : '0;
  assign endv   = ((top + TOP_W'(strip)) > TOP_W'(screen_height_r)) ?
                  TOP_W'(screen_height_r) : top + TOP_W'(strip);
  assign ypos   = TOP_W'(s1_out.row);
  assign in_strip = (strip != '0) && (ypos >= beginv) && (ypos < endv);
  assign tx_prod = s1_out.frac * texture_width_r;
  always_comb begin
    logic [TW_W-1:0] txr;
    txr = TW_W'(tx_prod >> 16);
    if (s1_out.mir) txr = texture_width_r - txr - TW_W'(1);
    tx = TXW_W'(txr);
  end

  // ok: pixel lies in the strip; hit: its key names a stored texture
  typedef struct packed {
    logic             ok;
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [TXW_W-1:0] tx;
    logic [rcs_pkg::STRIP_W-1:0] strip;
    logic             ns;
    logic [9:0]       col;
    logic [9:0]       row;
  } s2_side_t;

  logic a_valid_r;
  logic [16:0] off_r;
  s2_side_t a_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (!stall) a_valid_r <= s1_valid;
    if (!stall) begin
      off_r    <= 17'(ypos - top);
      a_side_r <= '{ok: in_strip, hit: s1_out.ok, key: s1_out.key, tx: tx, strip: strip,
                    ns: s1_out.ns, col: s1_out.col, row: s1_out.row};
    end
  end

  // stage B: scale the row offset
  logic b_valid_r;
  logic [NUM2_W-1:0] prod_r;
  s2_side_t b_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else if (!stall) b_valid_r <= a_valid_r;
    if (!stall) begin
      prod_r   <= NUM2_W'(off_r * texture_height_r);
      b_side_r <= a_side_r;
    end
  end

  // stage C: texture row division
  s2_side_t s2_out;
  logic [NUM2_W-1:0] ty_quot;
  logic s2_valid;
  // an empty strip is masked at the output; keep the divisor nonzero
  rcs_divider #(.NUM_W(NUM2_W), .DEN_W(rcs_pkg::STRIP_W), .SIDE_W($bits(s2_side_t)))
    u_row_div (
    .clk(clk), .rst_n(rst_n), .in_valid(b_valid_r), .stall(stall),
    .in_num(prod_r),
    .in_den((b_side_r.strip == '0) ? rcs_pkg::STRIP_W'(1) : b_side_r.strip),
    .in_side(b_side_r),
    .out_valid(s2_valid), .out_quot(ty_quot), .out_side(s2_out)
  );

  // renders accepted but not yet past their memory read; a write waits for zero
  // so it never overtakes an earlier render's read of the same texel
  logic [6:0] reads_pending_r;
  logic       rd_issue, rd_done;
  assign rd_issue = in_xfer && in_opcode == rcs_pkg::OP_RENDER;
  assign rd_done  = s2_valid && !stall;
  assign wr_block = (in_opcode == rcs_pkg::OP_WRITE) && (reads_pending_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) reads_pending_r <= '0;
    else reads_pending_r <= reads_pending_r + 7'(rd_issue) - 7'(rd_done);
  end

  // stage D: registered memory read
  logic d_valid_r;
  logic d_hit_r;
  rcs_pkg::rcs_tag_t d_tag_r;
  logic [23:0] rd_data_r;
  logic ty_ok;
  assign ty_ok = ty_quot < NUM2_W'(MAX_TEXTURE_HEIGHT);

  always_ff @(posedge clk) begin
    if (in_xfer && in_opcode == rcs_pkg::OP_WRITE && key_ok && wr_row_ok && wr_col_ok)
      tex_mem[wr_addr] <= in_texel_color;
    if (!stall)
      rd_data_r <= tex_mem[{s2_out.key, TXH_W'(ty_quot), s2_out.tx}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else if (!stall) d_valid_r <= s2_valid;
    if (!stall) begin
      d_tag_r <= '{ok: s2_out.ok, col: s2_out.col, row: s2_out.row, ns: s2_out.ns};
      d_hit_r <= ty_ok && s2_out.hit;
    end
  end

  // output register; a bad key inside the strip gives opaque black
  logic [7:0] r_c, g_c, b_c;
  always_comb begin
    r_c = d_hit_r ? rd_data_r[23:16] : 8'd0;
    g_c = d_hit_r ? rd_data_r[15:8]  : 8'd0;
    b_c = d_hit_r ? rd_data_r[7:0]   : 8'd0;
    if (d_tag_r.ns) begin
      r_c = r_c >> 1;
      g_c = g_c >> 1;
      b_c = b_c >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (!stall) out_valid <= d_valid_r;
    if (!stall) begin
      out_out_column  <= d_tag_r.col;
      out_out_row     <= d_tag_r.row;
      out_pixel_red   <= d_tag_r.ok ? r_c : 8'd0;
      out_pixel_green <= d_tag_r.ok ? g_c : 8'd0;
      out_pixel_blue  <= d_tag_r.ok ? b_c : 8'd0;
      out_pixel_alpha <= d_tag_r.ok ? 8'hFF : 8'd0;
    end
  end

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> out_valid) else $error("held output lost");
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_alpha == 8'd0 |-> out_pixel_red == 8'd0 &&
    out_pixel_green == 8'd0 && out_pixel_blue == 8'd0)
    else $error("transparent pixel carries colour");
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_alpha == 8'd0 || out_pixel_alpha == 8'hFF)
    else $error("alpha not binary");
endmodule

/* sv/rcs_divider.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rcs_divider #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 24,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              stall,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);
  localparam int REM_W = DEN_W + 1;

  logic [NUM_W-1:0]  num_r  [NUM_W+1];
  logic [DEN_W-1:0]  den_r  [NUM_W+1];
  logic [REM_W-1:0]  rem_r  [NUM_W+1];
  logic [SIDE_W-1:0] side_r [NUM_W+1];
  logic              vld_r  [NUM_W+1];

  always_comb begin
    num_r[0]  = in_num;
    den_r[0]  = in_den;
    rem_r[0]  = '0;
    side_r[0] = in_side;
    vld_r[0]  = in_valid;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic [NUM_W-1:0]  num_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  num_q;
    logic [DEN_W-1:0]  den_q;
    logic [REM_W-1:0]  rem_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;
    assign trial = {rem_r[s], num_r[s][NUM_W-1-s]};
    assign diff  = trial - {2'b00, den_r[s]};
    // quotient bit replaces the numerator bit just consumed
    always_comb begin
      num_nxt = num_r[s];
      num_nxt[NUM_W-1-s] = !diff[REM_W];
      rem_nxt = diff[REM_W] ? trial[REM_W-1:0] : diff[REM_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q <= 1'b0;
      end else if (!stall) begin
        vld_q <= vld_r[s];
      end
      if (!stall) begin
        den_q  <= den_r[s];
        side_q <= side_r[s];
        num_q  <= num_nxt;
        rem_q  <= rem_nxt;
      end
    end
    always_comb begin
      num_r[s+1]  = num_q;
      den_r[s+1]  = den_q;
      rem_r[s+1]  = rem_q;
      side_r[s+1] = side_q;
      vld_r[s+1]  = vld_q;
    end
  end

  assign out_valid = vld_r[NUM_W];
  assign out_quot  = num_r[NUM_W];
  assign out_side  = side_r[NUM_W];
endmodule

/* bench/raycast_wall_column_texel_shader_test.sv */
// testbench: texel writes and pixel renders checked against a bit-accurate predictor
`timescale 1ns / 1ps
module raycast_wall_column_texel_shader_test;
  localparam int LATENCY    = 55;
  localparam int DRAIN_WAIT = LATENCY + 20;
  localparam int CYCLE_CAP  = 400000;
  localparam int TEX_KEYS   = 8;
  localparam int TEX_DIM    = 64;
  localparam int SCREEN_MAX = 1024;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic        opcode;
    logic [3:0]  texture_key;
    logic [5:0]  texel_column;
    logic [5:0]  texel_row;
    logic [23:0] texel_color;
    logic [23:0] wall_distance;
    logic [15:0] hit_fraction;
    logic        wall_is_north_south;
    logic        ray_dir_x_positive;
    logic        ray_dir_y_negative;
    logic [9:0]  screen_column;
    logic [9:0]  screen_row;
  } shader_item_t;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = rcs_pkg::OP_WRITE;
  logic [3:0]  in_texture_key = '0;
  logic [5:0]  in_texel_column = '0;
  logic [5:0]  in_texel_row = '0;
  logic [23:0] in_texel_color = '0;
  logic [23:0] in_wall_distance = 24'd1;
  logic [15:0] in_hit_fraction = '0;
  logic        in_wall_is_north_south = 1'b0;
  logic        in_ray_dir_x_positive = 1'b0;
  logic        in_ray_dir_y_negative = 1'b0;
  logic [9:0]  in_screen_column = '0;
  logic [9:0]  in_screen_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_out_column, out_out_row;
  logic [7:0]  out_pixel_red, out_pixel_green, out_pixel_blue, out_pixel_alpha;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  raycast_wall_column_texel_shader u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_texture_key(in_texture_key),
    .in_texel_column(in_texel_column), .in_texel_row(in_texel_row),
    .in_texel_color(in_texel_color), .in_wall_distance(in_wall_distance),
    .in_hit_fraction(in_hit_fraction), .in_wall_is_north_south(in_wall_is_north_south),
    .in_ray_dir_x_positive(in_ray_dir_x_positive),
    .in_ray_dir_y_negative(in_ray_dir_y_negative),
    .in_screen_column(in_screen_column), .in_screen_row(in_screen_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_out_column(out_out_column), .out_out_row(out_out_row),
    .out_pixel_red(out_pixel_red), .out_pixel_green(out_pixel_green),
    .out_pixel_blue(out_pixel_blue), .out_pixel_alpha(out_pixel_alpha),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: its own copy of the registers and the texture memory
  int unsigned screen_h = 480;
  int unsigned tex_w = 64;
  int unsigned tex_h = 64;
  logic [23:0] tex_mem [0:TEX_KEYS*TEX_DIM*TEX_DIM-1];
  bit          tex_written [0:TEX_KEYS*TEX_DIM*TEX_DIM-1];

  pixel_t      pending_pixels [$];
  int          mismatches = 0;
  int          unexpected = 0;
  int          pixels_seen = 0;
  int          items_sent = 0;
  int          writes_sent = 0;
  int          strip_hits = 0;
  int unsigned cycles = 0;

  // idling controls; a long hold is requested by flipping hold_toggle
  bit          idle_on = 1'b1;
  bit          hold_toggle = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_cycles = 0;

  // clamp a register value into its legal range, as the block does on a write
  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // shade one render: returns the pixel and, when the strip is hit with a good
  // key, the texture memory address that the pixel reads
  function automatic pixel_t shade_pixel(input shader_item_t it, output bit reads_mem,
                                         output int unsigned addr);
    longint unsigned wall_dist, strip, tx, ty;
    longint          top, first_row, last_row, y;
    logic [23:0]     texel;
    pixel_t          px;
    px = '0;
    px.column = it.screen_column;
    px.row = it.screen_row;
    reads_mem = 1'b0;
    addr = 0;
    wall_dist = it.wall_distance;
    if (wall_dist == 0) wall_dist = 1;
    strip = (longint'(screen_h) << 16) / wall_dist;
    if (strip > 65535) strip = 65535;
    top = longint'(screen_h / 2) - longint'(strip / 2);
    first_row = top > 0 ? top : 0;
    last_row = top + longint'(strip);
    if (last_row > longint'(screen_h)) last_row = longint'(screen_h);
    y = it.screen_row;
    if (strip == 0 || y < first_row || y >= last_row) return px;
    tx = (longint'(it.hit_fraction) * tex_w) >> 16;
    // mirror the texture column for the two facing cases
    if ((it.wall_is_north_south && it.ray_dir_x_positive) ||
        (!it.wall_is_north_south && it.ray_dir_y_negative))
      tx = tex_w - tx - 1;
    ty = (longint'(y - top) * tex_h) / strip;
    texel = '0;
    if (it.texture_key >= 1 && it.texture_key <= TEX_KEYS) begin
      reads_mem = 1'b1;
      addr = 32'(((longint'(it.texture_key) - 1) * TEX_DIM + ty) * TEX_DIM + tx);
      texel = tex_mem[addr];
    end
    px.red = texel[23:16];
    px.green = texel[15:8];
    px.blue = texel[7:0];
    if (it.wall_is_north_south) begin
      px.red = px.red >> 1;
      px.green = px.green >> 1;
      px.blue = px.blue >> 1;
    end
    px.alpha = 8'hFF;
    return px;
  endfunction

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
               pending_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold counted here in cycles
  always @(posedge clk) begin
    if (hold_toggle != hold_ack) begin
      hold_ack <= hold_toggle;
      hold_cycles <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 19);
    end
  end

  // result checker: every output transfer against the oldest expected pixel
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_out_column, out_out_row, out_pixel_red, out_pixel_green,
              out_pixel_blue, out_pixel_alpha};
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel col %0d row %0d", got.column, got.row);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: exp col %0d row %0d rgba %h %h %h %h,",
                      " got col %0d row %0d rgba %h %h %h %h"},
                     want.column, want.row, want.red, want.green, want.blue, want.alpha,
                     got.column, got.row, got.red, got.green, got.blue, got.alpha);
        end
      end
    end
  end

  // present one item and hold it until the transfer, then update the predictor
  task automatic send_item(input shader_item_t it);
    int     gap;
    bit     reads_mem;
    int unsigned addr;
    pixel_t px;
    if (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= it.opcode;
    in_texture_key <= it.texture_key;
    in_texel_column <= it.texel_column;
    in_texel_row <= it.texel_row;
    in_texel_color <= it.texel_color;
    in_wall_distance <= it.wall_distance;
    in_hit_fraction <= it.hit_fraction;
    in_wall_is_north_south <= it.wall_is_north_south;
    in_ray_dir_x_positive <= it.ray_dir_x_positive;
    in_ray_dir_y_negative <= it.ray_dir_y_negative;
    in_screen_column <= it.screen_column;
    in_screen_row <= it.screen_row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (it.opcode == rcs_pkg::OP_WRITE) begin
      writes_sent++;
      if (it.texture_key >= 1 && it.texture_key <= TEX_KEYS) begin
        addr = ((it.texture_key - 1) * TEX_DIM + it.texel_row) * TEX_DIM + it.texel_column;
        tex_mem[addr] = it.texel_color;
        tex_written[addr] = 1'b1;
      end
    end else begin
      px = shade_pixel(it, reads_mem, addr);
      if (px.alpha != 0) strip_hits++;
      pending_pixels.push_back(px);
    end
  endtask

  // renders never read an unwritten texel: fill it first with a random colour
  task automatic issue(input shader_item_t it);
    shader_item_t fill;
    bit           reads_mem;
    int unsigned  addr;
    pixel_t       px;
    if (it.opcode == rcs_pkg::OP_RENDER) begin
      px = shade_pixel(it, reads_mem, addr);
      if (reads_mem && !tex_written[addr]) begin
        fill = it;
        fill.opcode = rcs_pkg::OP_WRITE;
        fill.texel_column = 6'(addr % TEX_DIM);
        fill.texel_row = 6'((addr / TEX_DIM) % TEX_DIM);
        fill.texel_color = 24'($urandom);
        send_item(fill);
      end
    end
    send_item(it);
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected pixel has come, then let the pipe go quiet
  task automatic drain();
    end_stream();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write through the config port, only with the block idle
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      rcs_pkg::REG_SCREEN_HEIGHT:  screen_h = clamp_reg(value & 32'h7FF, SCREEN_MAX);
      rcs_pkg::REG_TEXTURE_WIDTH:  tex_w = clamp_reg(value & 32'h7F, TEX_DIM);
      rcs_pkg::REG_TEXTURE_HEIGHT: tex_h = clamp_reg(value & 32'h7F, TEX_DIM);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic shader_item_t texel_write(input int key, input int col, input int row,
                                               input logic [23:0] colour);
    shader_item_t it;
    it = '{default: '0};
    it.opcode = rcs_pkg::OP_WRITE;
    it.texture_key = 4'(key);
    it.texel_column = 6'(col);
    it.texel_row = 6'(row);
    it.texel_color = colour;
    it.wall_distance = 24'($urandom);
    it.screen_row = 10'($urandom);
    return it;
  endfunction

  function automatic shader_item_t render(input int key, input logic [23:0] wall_dist,
                                          input logic [15:0] frac, input bit ns,
                                          input bit xpos, input bit yneg, input int row);
    shader_item_t it;
    it = '{default: '0};
    it.opcode = rcs_pkg::OP_RENDER;
    it.texture_key = 4'(key);
    it.texel_column = 6'($urandom);
    it.texel_row = 6'($urandom);
    it.texel_color = 24'($urandom);
    it.wall_distance = wall_dist;
    it.hit_fraction = frac;
    it.wall_is_north_south = ns;
    it.ray_dir_x_positive = xpos;
    it.ray_dir_y_negative = yneg;
    it.screen_column = 10'($urandom);
    it.screen_row = 10'(row);
    return it;
  endfunction

  // random render aimed mostly at the wall strip, across near, mid and far walls
  function automatic shader_item_t random_render();
    logic [23:0] wall_dist;
    int          key, row;
    case ($urandom_range(3))
      0: wall_dist = 24'($urandom_range(1, 24'h3FFF));
      1: wall_dist = 24'($urandom_range(24'h8000, 24'h7FFFF));
      2: wall_dist = 24'($urandom);
      default: wall_dist = ($urandom_range(9) == 0) ? 24'd0
                           : 24'(24'h10000 * $urandom_range(1, 4));
    endcase
    key = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, TEX_KEYS);
    row = $urandom_range(1) ? $urandom_range(0, 1023)
                            : $urandom_range(0, screen_h > 1023 ? 1023 : screen_h);
    return render(key, wall_dist, 16'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), row);
  endfunction

  function automatic shader_item_t random_write();
    return texel_write($urandom_range(0, 15), $urandom, $urandom, 24'($urandom));
  endfunction

  // extremes of the fields and the named corner cases at reset settings
  task automatic test_directed();
    issue(texel_write(1, 0, 0, 24'hFFFFFF));
    issue(texel_write(TEX_KEYS, 63, 63, 24'h80FF01));
    issue(texel_write(0, 5, 5, 24'h123456));       // bad key write, ignored
    issue(texel_write(15, 63, 63, 24'hABCDEF));    // bad key write, ignored
    issue(render(1, 24'd0, 16'h0000, 0, 0, 0, 240));           // zero distance
    issue(render(1, 24'hFFFFFF, 16'hFFFF, 1, 1, 0, 240));      // farthest wall
    issue(render(TEX_KEYS, 24'h10000, 16'hFFFF, 1, 0, 0, 0));  // top screen row
    issue(render(TEX_KEYS, 24'h10000, 16'hFFFF, 1, 1, 0, 479)); // mirrored n/s
    issue(render(2, 24'h10000, 16'h0000, 0, 0, 1, 300));       // mirrored e/w
    issue(render(2, 24'h10000, 16'h8000, 0, 1, 0, 300));
    issue(render(0, 24'h10000, 16'h4000, 0, 0, 0, 250));       // key zero: black
    issue(render(9, 24'h10000, 16'h4000, 1, 0, 0, 250));       // key too high
    issue(render(3, 24'h10000, 16'h1234, 0, 0, 0, 480));       // at screen height
    issue(render(3, 24'h10000, 16'h1234, 0, 0, 0, 1023));      // far below
    issue(render(3, 24'h40000, 16'h1234, 1, 1, 1, 10));        // ceiling
    issue(render(3, 24'h8000, 16'h1234, 0, 1, 1, 100));        // tall strip
  endtask

  // registers at their extremes, including clamped values
  task automatic test_config_sweep();
    int unsigned heights [6] = '{0, 1, 2047, 1024, 37, 480};
    int unsigned widths [5] = '{0, 127, 1, 33, 64};
    foreach (heights[i]) begin
      write_reg(rcs_pkg::REG_SCREEN_HEIGHT, heights[i]);
      write_reg(rcs_pkg::REG_TEXTURE_WIDTH, widths[i % 5]);
      write_reg(rcs_pkg::REG_TEXTURE_HEIGHT, widths[(i + 2) % 5]);
      // farthest wall; its strip is empty when the screen height is below 256
      issue(render(1, 24'hFFFFFF, 16'($urandom), 0, 0, 0, 0));
      repeat (8) issue(random_render());
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input;
  // keys outside the store read no texels, so the stream needs no fill writes
  task automatic test_backpressure();
    drain();
    hold_toggle = !hold_toggle;
    repeat (120)
      issue(render(($urandom_range(3) == 0) ? 0 : 9 + $urandom_range(6),
                   24'($urandom_range(24'h4000, 24'h3FFFF)), 16'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 1023)));
    drain();
  endtask

  // mostly renders with random content, some random and bad-key writes
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      idle_on = !(i >= count / 3 && i < count / 2);  // stretch with no idling
      if ($urandom_range(99) < 15) issue(random_write());
      else issue(random_render());
      if (i == count / 2) begin
        write_reg(rcs_pkg::REG_SCREEN_HEIGHT, $urandom_range(1, 1024));
        write_reg(rcs_pkg::REG_TEXTURE_WIDTH, $urandom_range(1, 64));
        write_reg(rcs_pkg::REG_TEXTURE_HEIGHT, $urandom_range(1, 64));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(500);
    drain();
    $display("covered %0d transfers in (%0d texel writes), %0d pixels out, %0d in the strip",
             items_sent, writes_sent, pixels_seen, strip_hits);
    $display("register extremes, clamping, mirroring, empty strips and a long output hold");
    if (mismatches == 0 && unexpected == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, pending_pixels.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
